FILE: rtl/core/ffa_pkg.sv
package ffa_pkg;

	// address and length widths of the arena
	localparam int ADDR_BITS = 16;
	localparam int LEN_W     = ADDR_BITS + 1;
	localparam int ALU_W     = LEN_W + 1;
	localparam int ENT_W     = ADDR_BITS + LEN_W;

	localparam logic [LEN_W-1:0] ARENA_MAX = {1'b1, {ADDR_BITS{1'b0}}};
	localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} ffa_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_LIST_FULL = 2'd2
	} ffa_status_t;

	typedef enum logic [2:0] {
		PATH_REUSED = 3'd0,
		PATH_BUMPED = 3'd1,
		PATH_POPPED = 3'd2,
		PATH_MERGED = 3'd3,
		PATH_LISTED = 3'd4
	} ffa_path_t;

	typedef struct packed {
		ffa_op_t               op;
		logic [ADDR_BITS-1:0]  block_addr;
		logic [ADDR_BITS-1:0]  block_size;
	} ffa_req_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0]  addr;
		ffa_status_t           status;
		ffa_path_t             path;
	} ffa_rsp_t;

	// shared add/subtract and compare unit
	typedef struct packed {
		logic              sub;
		logic [ALU_W-1:0]  a;
		logic [ALU_W-1:0]  b;
		logic [ALU_W-1:0]  c;
	} ffa_alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0]  sum;
		logic              eq;
		logic              le;
	} ffa_alu_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_CMP,
		S_A_SPLIT1,
		S_A_SPLIT2,
		S_A_BUMP,
		S_F_TOP,
		S_F_RD,
		S_F_CMP,
		S_F_M1,
		S_F_M2,
		S_F_APP,
		S_D_RD,
		S_D_WR,
		S_DONE
	} ffa_state_t;

endpackage

FILE: rtl/core/ffa_ram.sv
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/ffa_alu.sv
module ffa_alu import ffa_pkg::*; (
	input  ffa_alu_req_t  req,
	output ffa_alu_rsp_t  rsp
);

	logic [ALU_W-1:0] b_eff;
	logic [ALU_W-1:0] sum;

	// a plus or minus b, then compared against c
	assign b_eff   = req.sub ? ~req.b : req.b;
	assign sum     = req.a + b_eff + ALU_W'(req.sub);
	assign rsp.sum = sum;
	assign rsp.eq  = (sum == req.c);
	assign rsp.le  = (sum <= req.c);

endmodule

FILE: rtl/core/first_fit_free_list_allocator_unit.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  ffa_req_t   (op, block_addr, block_size)
// rsp       out        rsp_valid / rsp_stall  ffa_rsp_t   (addr, status, path)
// cfg       in         cfg_valid / cfg_ready  cfg_data    (arena_size, 17 bits)
//
// One item at a time. Allocate compares each free entry in turn and takes the first that
// fits, splitting it or on an exact fit dropping it, else bumps the top; free pops a block
// ending at the top, else scans for a neighbouring entry to merge with (popping the merge
// if it reaches the top) or appends a new entry. req_stall is high until the result load
// and the next item can be taken in the cycle after it. Reset is asynchronous; the free
// list memory is not cleared, only the count, the top and the arena size.
module first_fit_free_list_allocator_unit import ffa_pkg::*; #(
	parameter int FREE_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ffa_req_t          req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ffa_rsp_t          rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LEN_W-1:0]  cfg_data
);

	localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FREE_ENTRIES);

	ffa_state_t state_q, state_d;

	ffa_op_t               op_q;
	logic [ADDR_BITS-1:0]  baddr_q, bsize_q, ms_q;
	logic [LEN_W-1:0]      bend_q, top_q, arena_q;
	logic [ALU_W-1:0]      tmp_q;
	logic [CNT_W-1:0]      idx_q, count_q, cnt_last;
	logic [ADDR_BITS-1:0]  res_addr_q;
	ffa_status_t           res_status_q;
	ffa_path_t             res_path_q;
	ffa_rsp_t              rsp_q;
	logic                  rsp_valid_q;

	ffa_alu_req_t          alu_req;
	ffa_alu_rsp_t          alu_rsp;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr, ram_raddr;
	logic [ENT_W-1:0]      ram_wdata, ram_rdata;

	logic [ADDR_BITS-1:0]  ent_start;
	logic [LEN_W-1:0]      ent_len, sat_len;
	logic                  req_take, rsp_load, at_end, bend_hit, list_full;

	ffa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (FREE_ENTRIES)
	) u_list (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ffa_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// handshakes and helpers
	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	assign ent_start = ram_rdata[ENT_W-1 -: ADDR_BITS];
	assign ent_len   = ram_rdata[LEN_W-1:0];
	assign at_end    = (idx_q == count_q);
	assign cnt_last  = count_q - 1'b1;
	assign bend_hit  = (bend_q == LEN_W'(ent_start));
	assign list_full = (count_q == CNT_FULL);
	assign sat_len   = alu_rsp.sum[LEN_W] ? LEN_MAX : alu_rsp.sum[LEN_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (req.op == OP_ALLOC) ? S_A_RD : S_F_TOP;
				end
			end
			S_A_RD:     state_d = at_end ? S_A_BUMP : S_A_CMP;
			S_A_CMP: begin
				if (alu_rsp.le) begin
					state_d = alu_rsp.eq ? S_D_RD : S_A_SPLIT1;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_SPLIT1: state_d = S_A_SPLIT2;
			S_A_SPLIT2: state_d = S_DONE;
			S_A_BUMP:   state_d = S_DONE;
			S_F_TOP:    state_d = alu_rsp.eq ? S_DONE : S_F_RD;
			S_F_RD:     state_d = at_end ? S_F_APP : S_F_CMP;
			S_F_CMP:    state_d = (alu_rsp.eq || bend_hit) ? S_F_M1 : S_F_RD;
			S_F_M1:     state_d = alu_rsp.eq ? S_F_RD : S_F_M2;
			S_F_M2:     state_d = alu_rsp.eq ? S_D_RD : S_DONE;
			S_F_APP:    state_d = S_DONE;
			S_D_RD:     state_d = S_D_WR;
			S_D_WR:     state_d = S_DONE;
			S_DONE:     state_d = rsp_load ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	// shared unit operands
	always_comb begin
		alu_req = '0;
		unique case (state_q)
			S_A_CMP: begin
				// size <= entry length, equal means exact fit
				alu_req.a = ALU_W'(bsize_q);
				alu_req.c = ALU_W'(ent_len);
			end
			S_A_SPLIT1: begin
				alu_req.sub = 1'b1;
				alu_req.a   = ALU_W'(ent_len);
				alu_req.b   = ALU_W'(bsize_q);
			end
			S_A_SPLIT2: begin
				alu_req.a = ALU_W'(ent_start);
				alu_req.b = ALU_W'(bsize_q);
			end
			S_A_BUMP: begin
				alu_req.a = ALU_W'(top_q);
				alu_req.b = ALU_W'(bsize_q);
				alu_req.c = ALU_W'(arena_q);
			end
			S_F_TOP: begin
				alu_req.a = ALU_W'(baddr_q);
				alu_req.b = ALU_W'(bsize_q);
				alu_req.c = ALU_W'(top_q);
			end
			S_F_CMP: begin
				// entry ends where the block starts
				alu_req.a = ALU_W'(ent_start);
				alu_req.b = ALU_W'(ent_len);
				alu_req.c = ALU_W'(baddr_q);
			end
			S_F_M1: begin
				// merged length, zero means skip
				alu_req.a = ALU_W'(ent_len);
				alu_req.b = ALU_W'(bsize_q);
			end
			S_F_M2: begin
				alu_req.a = ALU_W'(ms_q);
				alu_req.b = tmp_q;
				alu_req.c = ALU_W'(top_q);
			end
			default: begin
			end
		endcase
	end

	// free list memory ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_A_SPLIT2: begin
				// entry start advances by the size, wrapping
				ram_we    = 1'b1;
				ram_wdata = {alu_rsp.sum[ADDR_BITS-1:0], tmp_q[LEN_W-1:0]};
			end
			S_F_M2: begin
				ram_we    = !alu_rsp.eq;
				ram_wdata = {ms_q, tmp_q[LEN_W-1:0]};
			end
			S_F_APP: begin
				ram_we    = !list_full;
				ram_waddr = count_q[IDX_W-1:0];
				ram_wdata = {baddr_q, LEN_W'(bsize_q)};
			end
			S_D_RD: begin
				ram_raddr = cnt_last[IDX_W-1:0];
			end
			S_D_WR: begin
				// last entry moves into the freed slot
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			top_q       <= '0;
			arena_q     <= ARENA_MAX;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				arena_q <= (cfg_data > ARENA_MAX) ? ARENA_MAX : cfg_data;
			end
			unique case (state_q)
				S_A_BUMP: begin
					if (alu_rsp.le) begin
						top_q <= alu_rsp.sum[LEN_W-1:0];
					end
				end
				S_F_TOP: begin
					if (alu_rsp.eq) begin
						top_q <= LEN_W'(baddr_q);
					end
				end
				S_F_M2: begin
					if (alu_rsp.eq) begin
						top_q <= LEN_W'(ms_q);
					end
				end
				S_F_APP: begin
					if (!list_full) begin
						count_q <= count_q + 1'b1;
					end
				end
				S_D_WR:  count_q <= cnt_last;
				default: begin
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item registers and result fields
	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q         <= req.op;
			baddr_q      <= req.block_addr;
			bsize_q      <= req.block_size;
			idx_q        <= '0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
			res_path_q   <= (req.op == OP_ALLOC) ? PATH_REUSED : PATH_LISTED;
		end
		unique case (state_q)
			S_A_CMP: begin
				if (alu_rsp.le) begin
					res_addr_q <= ent_start;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_A_SPLIT1: tmp_q <= alu_rsp.sum;
			S_A_BUMP: begin
				res_path_q <= PATH_BUMPED;
				if (alu_rsp.le) begin
					res_addr_q <= top_q[ADDR_BITS-1:0];
				end else begin
					res_status_q <= ST_NO_SPACE;
				end
			end
			S_F_TOP: begin
				bend_q <= alu_rsp.sum[LEN_W-1:0];
				if (alu_rsp.eq) begin
					res_path_q <= PATH_POPPED;
				end
			end
			S_F_CMP: begin
				if (alu_rsp.eq) begin
					ms_q <= ent_start;
				end else if (bend_hit) begin
					ms_q <= baddr_q;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_F_M1: begin
				if (alu_rsp.eq) begin
					idx_q <= idx_q + 1'b1;
				end else begin
					tmp_q <= ALU_W'(sat_len);
				end
			end
			S_F_M2:  res_path_q <= PATH_MERGED;
			S_F_APP: begin
				if (list_full) begin
					res_status_q <= ST_LIST_FULL;
				end
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			rsp_q.addr   <= (op_q == OP_ALLOC) ? res_addr_q : '0;
			rsp_q.status <= res_status_q;
			rsp_q.path   <= res_path_q;
		end
	end

	// entry count stays within the list
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
	else $error("free entry count beyond list depth");

	// a drop only happens with a nonempty list
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_D_WR) |-> (count_q != '0))
	else $error("entry removal from an empty list");

	// leaving the done state always presents a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && state_d == S_IDLE) |=> rsp_valid_q)
	else $error("item finished without a result");

	// an accepted item starts work at once
	assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (state_q != S_IDLE))
	else $error("accepted item dropped");

	// a pending result is not overwritten while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !rsp_load)
	else $error("stalled result overwritten");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ffa_pkg::*;

	localparam int HOLE_SLOTS = 16;
	localparam int SETTLE_CYCLES = 2 * HOLE_SLOTS + 10;
	localparam logic [LEN_W-1:0] ARENA_STEPS [7] = '{
		17'd0, 17'd1, 17'd300, 17'd131071, 17'd5000, 17'd65535, 17'd65536
	};

	// shadow copy of the allocator: bump pointer plus hole list
	typedef struct packed {
		logic [LEN_W-1:0]                          arena;
		logic [LEN_W-1:0]                          top;
		logic [4:0]                                count;
		logic [HOLE_SLOTS-1:0][ADDR_BITS-1:0]      starts;
		logic [HOLE_SLOTS-1:0][LEN_W-1:0]          lens;
	} arena_state_t;

	// a block handed out and not yet given back
	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [ADDR_BITS-1:0] bytes;
	} span_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	ffa_req_t         req = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	ffa_rsp_t         rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data = '0;

	arena_state_t arena_now;
	arena_state_t arena_plan;
	ffa_req_t     pending_req [$];
	ffa_rsp_t     expected_rsp [$];
	span_t        live_spans [$];
	ffa_rsp_t     want;
	int           send_gap = 0;
	int           hold_left = 0;
	int           stall_draw;
	int           queued_total = 0;
	int           results_seen = 0;
	int           mismatches = 0;
	bit           long_hold_done = 1'b0;
	bit           steady = 1'b0;

	first_fit_free_list_allocator_unit #(
		.FREE_ENTRIES(HOLE_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// move the last hole into the given slot
	function automatic void remove_hole(inout arena_state_t s, input int slot);
		int last;
		last = int'(s.count) - 1;
		s.starts[slot] = s.starts[last];
		s.lens[slot] = s.lens[last];
		s.count = 5'(last);
	endfunction

	// one request against the shadow state, returns the result it must give
	function automatic ffa_rsp_t serve_request(inout arena_state_t s, input ffa_req_t r);
		ffa_rsp_t o;
		int       bend;
		int       ms;
		int       ml;
		bit       hit;
		bit       done;
		o.addr = '0;
		o.status = ST_OK;
		o.path = PATH_REUSED;
		done = 1'b0;
		if (r.op == OP_ALLOC) begin
			// first hole large enough wins
			for (int i = 0; i < int'(s.count) && !done; i++) begin
				if (s.lens[i] >= LEN_W'(r.block_size)) begin
					o.addr = s.starts[i];
					o.path = PATH_REUSED;
					done = 1'b1;
					if (s.lens[i] > LEN_W'(r.block_size)) begin
						s.starts[i] = s.starts[i] + r.block_size;
						s.lens[i] = s.lens[i] - LEN_W'(r.block_size);
					end else begin
						remove_hole(s, i);
					end
				end
			end
			// otherwise bump the top
			if (!done) begin
				o.path = PATH_BUMPED;
				if (int'(s.top) + int'(r.block_size) > int'(s.arena)) begin
					o.status = ST_NO_SPACE;
				end else begin
					o.addr = s.top[ADDR_BITS-1:0];
					s.top = s.top + LEN_W'(r.block_size);
				end
			end
		end else begin
			bend = int'(r.block_addr) + int'(r.block_size);
			if (bend == int'(s.top)) begin
				s.top = s.top - LEN_W'(r.block_size);
				o.path = PATH_POPPED;
			end else begin
				// merge with the first neighboring hole
				for (int i = 0; i < int'(s.count) && !done; i++) begin
					hit = 1'b0;
					if (int'(s.starts[i]) + int'(s.lens[i]) == int'(r.block_addr)) begin
						ms = int'(s.starts[i]);
						ml = int'(s.lens[i]) + int'(r.block_size);
						hit = 1'b1;
					end else if (bend == int'(s.starts[i])) begin
						ms = int'(r.block_addr);
						ml = int'(r.block_size) + int'(s.lens[i]);
						hit = 1'b1;
					end
					if (hit && ml > 0) begin
						if (ml > int'(LEN_MAX)) ml = int'(LEN_MAX);
						if (ms + ml == int'(s.top)) begin
							s.top = s.top - LEN_W'(ml);
							remove_hole(s, i);
						end else begin
							s.starts[i] = ms[ADDR_BITS-1:0];
							s.lens[i] = ml[LEN_W-1:0];
						end
						o.path = PATH_MERGED;
						done = 1'b1;
					end
				end
				// append a new hole
				if (!done) begin
					o.path = PATH_LISTED;
					if (int'(s.count) >= HOLE_SLOTS) begin
						o.status = ST_LIST_FULL;
					end else begin
						s.starts[s.count] = r.block_addr;
						s.lens[s.count] = LEN_W'(r.block_size);
						s.count = s.count + 5'd1;
					end
				end
			end
		end
		return o;
	endfunction

	// queue an item, tracking what the allocator hands out
	task automatic queue_request(input ffa_op_t op, input logic [ADDR_BITS-1:0] a,
		input logic [ADDR_BITS-1:0] n);
		ffa_req_t r;
		ffa_rsp_t o;
		r.op = op;
		r.block_addr = a;
		r.block_size = n;
		o = serve_request(arena_plan, r);
		if (op == OP_ALLOC && o.status == ST_OK && n != 0)
			live_spans.push_back('{base: o.addr, bytes: n});
		pending_req.push_back(r);
		queued_total++;
	endtask

	// mostly alloc/free traffic on live blocks, some junk
	task automatic random_request();
		int                   pick;
		int                   idx;
		int                   k;
		span_t                sp;
		logic [ADDR_BITS-1:0] n;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			case ($urandom_range(0, 3))
				0: queue_request(OP_ALLOC, 16'($urandom), 16'($urandom));
				1: queue_request(OP_FREE, 16'($urandom), 16'($urandom));
				2: queue_request(OP_ALLOC, 16'($urandom), 16'd0);
				default: begin
					n = 16'($urandom_range(0, 32));
					queue_request(OP_FREE, arena_plan.top[ADDR_BITS-1:0] - n, n);
				end
			endcase
		end else if (live_spans.size() > 0 && (pick < 52 || live_spans.size() > 24)) begin
			idx = $urandom_range(0, live_spans.size() - 1);
			sp = live_spans[idx];
			live_spans.delete(idx);
			// sometimes give back only the head and keep the tail
			if (sp.bytes > 1 && $urandom_range(0, 4) == 0) begin
				k = $urandom_range(1, sp.bytes - 1);
				live_spans.push_back('{base: sp.base + 16'(k), bytes: sp.bytes - 16'(k)});
				queue_request(OP_FREE, sp.base, 16'(k));
			end else begin
				queue_request(OP_FREE, sp.base, sp.bytes);
			end
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 70) n = 16'($urandom_range(1, 64));
			else if (pick < 95) n = 16'($urandom_range(1, 2048));
			else n = 16'($urandom);
			queue_request(OP_ALLOC, 16'($urandom), n);
		end
	endtask

	task automatic wait_drained();
		while (results_seen < queued_total) @(posedge clk);
	endtask

	task automatic write_arena(input logic [LEN_W-1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		arena_now.arena = (v > ARENA_MAX) ? ARENA_MAX : v;
		arena_plan = arena_now;
	endtask

	// request driver: predict on acceptance, then idle or load the next item
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (req_valid && !req_stall)
				expected_rsp.push_back(serve_request(arena_now, req));
			if (!req_valid || !req_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (pending_req.size() > 0) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
					send_gap <= steady ? 0 : $urandom_range(0, 10);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare against the oldest prediction, then stall a while
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
		end else if (rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t unexpected item: addr=%0h status=%0d path=%0d",
					$time, rsp.addr, rsp.status, rsp.path);
				mismatches++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.addr != want.addr) begin
					$display("%0t addr mismatch: expected %0h, got %0h",
						$time, want.addr, rsp.addr);
					mismatches++;
				end
				if (rsp.status != want.status) begin
					$display("%0t status mismatch: expected %0d, got %0d",
						$time, want.status, rsp.status);
					mismatches++;
				end
				if (rsp.path != want.path) begin
					$display("%0t path mismatch: expected %0d, got %0d",
						$time, want.path, rsp.path);
					mismatches++;
				end
			end
			results_seen++;
			// one long hold-off so the block backs up into its input
			if (!long_hold_done && results_seen == 300) begin
				stall_draw = 400;
				long_hold_done = 1'b1;
			end else begin
				stall_draw = steady ? 0 : $urandom_range(0, 10);
			end
			rsp_stall <= (stall_draw > 0);
			hold_left <= stall_draw;
		end else if (hold_left > 0) begin
			rsp_stall <= (hold_left > 1);
			hold_left <= hold_left - 1;
		end
	end

	initial begin
		int phase;
		arena_now.arena = ARENA_MAX;
		arena_now.top = '0;
		arena_now.count = '0;
		arena_now.starts = '0;
		arena_now.lens = '0;
		arena_plan = arena_now;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk through every path at the reset arena size
		queue_request(OP_ALLOC, 16'd0, 16'd100);
		queue_request(OP_ALLOC, 16'hffff, 16'd200);
		queue_request(OP_ALLOC, 16'd0, 16'd300);
		queue_request(OP_FREE, 16'd100, 16'd200);
		queue_request(OP_ALLOC, 16'd0, 16'd50);
		queue_request(OP_ALLOC, 16'd0, 16'd150);
		queue_request(OP_ALLOC, 16'd0, 16'd0);
		queue_request(OP_FREE, 16'd300, 16'd300);
		queue_request(OP_FREE, 16'd300, 16'd0);
		queue_request(OP_FREE, 16'd10, 16'd0);
		queue_request(OP_ALLOC, 16'd0, 16'd0);
		queue_request(OP_FREE, 16'd0, 16'd50);
		queue_request(OP_ALLOC, 16'd0, 16'd0);
		queue_request(OP_FREE, 16'd50, 16'd25);
		queue_request(OP_FREE, 16'd80, 16'd0);
		queue_request(OP_FREE, 16'd80, 16'd0);
		queue_request(OP_FREE, 16'd78, 16'd2);
		queue_request(OP_FREE, 16'd200, 16'd50);
		queue_request(OP_FREE, 16'd250, 16'd50);
		queue_request(OP_FREE, 16'd190, 16'd10);
		queue_request(OP_ALLOC, 16'd0, 16'hffff);
		queue_request(OP_FREE, 16'hffff, 16'hffff);
		queue_request(OP_ALLOC, 16'd0, 16'hffff);
		queue_request(OP_ALLOC, 16'd0, 16'd65346);
		queue_request(OP_ALLOC, 16'd0, 16'd1);
		queue_request(OP_FREE, 16'd190, 16'd65346);
		wait_drained();

		// random traffic across a range of arena sizes
		for (phase = 0; phase < 8; phase++) begin
			steady = (phase % 3 == 1);
			repeat (SETTLE_CYCLES) @(posedge clk);
			write_arena(phase < 7 ? ARENA_STEPS[phase] : LEN_W'($urandom_range(0, 131071)));
			// scattered frees fill the hole list until it overflows
			if (phase == 0) begin
				for (int i = 0; i < 18; i++)
					queue_request(OP_FREE, 16'(20000 + 8 * i), 16'd3);
			end
			repeat (150) random_request();
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS first_fit_free_list_allocator_unit");
		end else begin
			$display("FAIL first_fit_free_list_allocator_unit");
		end
		$finish;
	end

	// watchdog
	initial begin
		#12_000_000;
		$display("FAIL first_fit_free_list_allocator_unit");
		$finish;
	end

endmodule
